### rtl/brfo_pkg.sv
package brfo_pkg;

    // Built store depth and derived widths.
    localparam int unsigned DEPTH = 256;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = AW + 1;

    // Capacity after reset.
    localparam logic [CW-1:0] CAP_RESET = CW'(DEPTH);

    // Operation codes.
    localparam logic [2:0] OP_RESET  = 3'd0;
    localparam logic [2:0] OP_WR_BYTE = 3'd1;
    localparam logic [2:0] OP_WR_WORD = 3'd2;
    localparam logic [2:0] OP_RD_BYTE = 3'd3;
    localparam logic [2:0] OP_RD_WORD = 3'd4;
    localparam logic [2:0] OP_REWIND = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clear;
        logic wr;
        logic wr_hi;
        logic rd;
        logic cap_lo;
        logic fail;
        logic rewind;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       under_two;
        logic       out_free;
    } t_sts;

    // Advance a ring position, wrapping at the capacity.
    function automatic logic [AW-1:0] f_step(input logic [AW-1:0] p, input logic [CW-1:0] cap);
        logic [CW-1:0] n;
        n = {1'b0, p} + CW'(1);
        return (n >= cap) ? '0 : n[AW-1:0];
    endfunction

    // Number of bytes held.
    function automatic logic [CW-1:0] f_fill(input logic [AW-1:0] head, input logic [AW-1:0] tail,
                                             input logic full, input logic [CW-1:0] cap);
        logic [CW-1:0] r;
        if (full) begin
            r = cap;
        end else if (head >= tail) begin
            r = {1'b0, head} - {1'b0, tail};
        end else begin
            r = cap + {1'b0, head} - {1'b0, tail};
        end
        return r;
    endfunction

endpackage

### rtl/byte_ring_fifo_overwrite_core.sv
// Each result passes the controller states STEP1 and FINISH, with STEP2 between them for word
// writes and word reads that succeed, and is then loaded into the output register. The single
// store port moves one byte per cycle and the controller works on one item at a time.
// An input is taken while an earlier result still waits in the output register.
// Reset (synchronous, active low) empties the ring, sets the capacity to 256 and clears the
// written marks, so every slot reads as zero until written; no clearing pass is needed.
module byte_ring_fifo_overwrite_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [brfo_pkg::CW-1:0]   i_cfg_wr_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_operation,
    input  logic [15:0]               i_write_value,
    input  logic [brfo_pkg::CW-1:0]   i_rewind_length,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [15:0]               o_read_value,
    output logic                      o_status,
    output logic [brfo_pkg::CW-1:0]   o_fill_level,
    output logic                      o_full_flag,
    output logic                      o_empty_flag
);

    brfo_pkg::t_cmd cmd;
    brfo_pkg::t_sts sts;

    // Operation sequencer.
    brfo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Store, positions and output register.
    brfo_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_operation     (i_operation),
        .i_write_value   (i_write_value),
        .i_rewind_length (i_rewind_length),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_fill_level    (o_fill_level),
        .o_full_flag     (o_full_flag),
        .o_empty_flag    (o_empty_flag)
    );

endmodule

### rtl/brfo_ctrl.sv
module brfo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  brfo_pkg::t_sts  i_sts,
    output brfo_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STEP1  = 2'd1;
    localparam logic [1:0] S_STEP2  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    brfo_pkg::t_cmd cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    // Sequence each operation over one or two byte steps, then hand off the result.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_STEP1;
                end
            end
            S_STEP1: begin
                n_state = S_FINISH;
                unique case (i_sts.op)
                    brfo_pkg::OP_RESET: begin
                        cmd.clear = 1'b1;
                    end
                    brfo_pkg::OP_WR_BYTE: begin
                        cmd.wr = 1'b1;
                    end
                    brfo_pkg::OP_WR_WORD: begin
                        cmd.wr  = 1'b1;
                        n_state = S_STEP2;
                    end
                    brfo_pkg::OP_RD_BYTE: begin
                        if (i_sts.empty) begin
                            cmd.fail = 1'b1;
                        end else begin
                            cmd.rd = 1'b1;
                        end
                    end
                    brfo_pkg::OP_RD_WORD: begin
                        if (i_sts.under_two) begin
                            cmd.fail = 1'b1;
                        end else begin
                            cmd.rd  = 1'b1;
                            n_state = S_STEP2;
                        end
                    end
                    brfo_pkg::OP_REWIND: begin
                        cmd.rewind = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_STEP2: begin
                n_state = S_FINISH;
                if (i_sts.op == brfo_pkg::OP_WR_WORD) begin
                    cmd.wr    = 1'b1;
                    cmd.wr_hi = 1'b1;
                end else begin
                    cmd.cap_lo = 1'b1;
                    cmd.rd     = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/brfo_dpath.sv
module brfo_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  brfo_pkg::t_cmd            i_cmd,
    output brfo_pkg::t_sts            o_sts,
    input  logic                      i_cfg_wr_en,
    input  logic [brfo_pkg::CW-1:0]   i_cfg_wr_data,
    input  logic [2:0]                i_operation,
    input  logic [15:0]               i_write_value,
    input  logic [brfo_pkg::CW-1:0]   i_rewind_length,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [15:0]               o_read_value,
    output logic                      o_status,
    output logic [brfo_pkg::CW-1:0]   o_fill_level,
    output logic                      o_full_flag,
    output logic                      o_empty_flag
);

    // Byte store with a written mark per slot; an unwritten slot reads as zero.
    logic [7:0]                 mem [brfo_pkg::DEPTH];
    logic [brfo_pkg::DEPTH-1:0] r_written;
    logic [7:0]                 r_q;
    logic                       r_q_vld;

    logic [brfo_pkg::AW-1:0] r_head, n_head;
    logic [brfo_pkg::AW-1:0] r_tail, n_tail;
    logic                    r_full, n_full;
    logic [brfo_pkg::CW-1:0] r_cap;
    logic [brfo_pkg::CW-1:0] cfg_cap;

    logic [2:0]              r_op;
    logic [15:0]             r_wval;
    logic [brfo_pkg::CW-1:0] r_len;
    logic                    r_fail;
    logic [7:0]              r_lo;

    logic [7:0]              rd_byte;
    logic [7:0]              wr_byte;
    logic [brfo_pkg::CW-1:0] fill;
    logic                    empty;
    logic [brfo_pkg::CW-1:0] clamp_len;
    logic [brfo_pkg::CW:0]   rew_sum;
    logic [brfo_pkg::AW-1:0] head_step;
    logic [15:0]             res_value;

    logic                    r_o_valid;
    logic [15:0]             r_o_value;
    logic                    r_o_status;
    logic [brfo_pkg::CW-1:0] r_o_fill;
    logic                    r_o_full;
    logic                    r_o_empty;

    // Current level and flags.
    assign fill    = brfo_pkg::f_fill(r_head, r_tail, r_full, r_cap);
    assign empty   = !r_full && (r_head == r_tail);
    assign rd_byte = r_q_vld ? r_q : 8'h00;
    assign wr_byte = i_cmd.wr_hi ? r_wval[15:8] : r_wval[7:0];

    assign o_sts.op        = r_op;
    assign o_sts.empty     = empty;
    assign o_sts.under_two = (fill < brfo_pkg::CW'(2));
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    // Clamp a configured capacity to 1..DEPTH.
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            cfg_cap = brfo_pkg::CW'(1);
        end else if (i_cfg_wr_data > brfo_pkg::CAP_RESET) begin
            cfg_cap = brfo_pkg::CAP_RESET;
        end else begin
            cfg_cap = i_cfg_wr_data;
        end
    end

    // Rewind target: head minus the clamped length, modulo the capacity.
    assign clamp_len = (r_len > r_cap) ? r_cap : r_len;
    assign rew_sum   = {2'b00, r_head} + {1'b0, r_cap} - {1'b0, clamp_len};
    assign head_step = brfo_pkg::f_step(r_head, r_cap);

    // Next head, tail and full mark.
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_full = r_full;
        if (i_cmd.clear) begin
            n_head = '0;
            n_tail = '0;
            n_full = 1'b0;
        end else if (i_cmd.wr) begin
            n_head = head_step;
            if (r_full) begin
                n_tail = brfo_pkg::f_step(r_tail, r_cap);
            end
            n_full = (head_step == n_tail);
        end else if (i_cmd.rd) begin
            n_tail = brfo_pkg::f_step(r_tail, r_cap);
            n_full = 1'b0;
        end else if (i_cmd.rewind) begin
            if (rew_sum >= {1'b0, r_cap}) begin
                n_tail = brfo_pkg::AW'(rew_sum - {1'b0, r_cap});
            end else begin
                n_tail = brfo_pkg::AW'(rew_sum);
            end
        end
    end

    // Position and capacity registers; a capacity write empties the ring.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_full <= 1'b0;
            r_cap  <= brfo_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_head <= '0;
            r_tail <= '0;
            r_full <= 1'b0;
            r_cap  <= cfg_cap;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_full <= n_full;
        end
    end

    // Store write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[r_head] <= wr_byte;
        end
    end

    // Written marks, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_cmd.wr) begin
            r_written[r_head] <= 1'b1;
        end
    end

    // Registered store read at the tail.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_q     <= mem[r_tail];
            r_q_vld <= r_written[r_tail];
        end
    end

    // Latch the accepted item and track the low byte and failure of a read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= brfo_pkg::OP_RESET;
            r_fail <= 1'b0;
        end else if (i_cmd.load) begin
            r_op   <= i_operation;
            r_fail <= 1'b0;
        end else if (i_cmd.fail) begin
            r_fail <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wval <= i_write_value;
            r_len  <= i_rewind_length;
        end
        if (i_cmd.cap_lo) begin
            r_lo <= rd_byte;
        end
    end

    // Read data of the finished operation.
    always_comb begin
        if (r_fail) begin
            res_value = 16'h0000;
        end else if (r_op == brfo_pkg::OP_RD_BYTE) begin
            res_value = {8'h00, rd_byte};
        end else if (r_op == brfo_pkg::OP_RD_WORD) begin
            res_value = {rd_byte, r_lo};
        end else begin
            res_value = 16'h0000;
        end
    end

    // Output register; the result waits here until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_value  <= res_value;
            r_o_status <= r_fail;
            r_o_fill   <= fill;
            r_o_full   <= r_full;
            r_o_empty  <= empty;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_read_value = r_o_value;
    assign o_status     = r_o_status;
    assign o_fill_level = r_o_fill;
    assign o_full_flag  = r_o_full;
    assign o_empty_flag = r_o_empty;

endmodule

### rtl/brfo_checker.sv
module brfo_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [15:0]             o_read_value,
    input logic                    o_status,
    input logic [brfo_pkg::CW-1:0] o_fill_level,
    input logic                    o_full_flag,
    input logic                    o_empty_flag
);

    // A failed read reports no data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_read_value == 16'h0000))
        else $error("failed read reports nonzero data");

    // Full and empty never show together.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_full_flag && o_empty_flag))
        else $error("full and empty both set");

    // The empty flag matches a zero level.
    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_flag) |-> (o_fill_level == '0))
        else $error("empty with nonzero level");

    // A stalled result holds until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_value)))
        else $error("result changed while stalled");

endmodule

bind byte_ring_fifo_overwrite_core brfo_checker u_brfo_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_value (o_read_value),
    .o_status     (o_status),
    .o_fill_level (o_fill_level),
    .o_full_flag  (o_full_flag),
    .o_empty_flag (o_empty_flag)
);
